### rtl/tsw_pkg.sv
// ----------------------------------------------------------------------------
// tsw_pkg
// shared constants, codes and controller/datapath interface types for the
// timed square-wave tone generator
// ----------------------------------------------------------------------------
package tsw_pkg;

	localparam int unsigned CLOCK_HZ      = 2000000;
	localparam int unsigned TICKS_PER_MS  = 2000;
	localparam int unsigned SILENT_PERIOD = 2000;

	localparam int unsigned CNT_W   = 16;
	localparam int unsigned REM_W   = 27;
	localparam int unsigned FREQ_W  = 16;
	localparam int unsigned MS_W    = 16;
	localparam int unsigned PROD_W  = 32;

	// quotient bits of the clock rate division
	localparam int unsigned DIV_BITS = $clog2(CLOCK_HZ + 1);
	localparam int unsigned STEP_W   = $clog2(DIV_BITS);

	localparam logic [CNT_W-1:0] PERIOD_MAX   = '1;
	localparam logic [CNT_W-1:0] PERIOD_RESET = CNT_W'(100);
	localparam logic [REM_W-1:0] REM_MAX      = '1;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_PLAY = 2'd1,
		ACT_STOP = 2'd2
	} tsw_action_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} tsw_state_t;

	typedef struct packed {
		logic tick;        // advance the counter by one clock tick
		logic play;        // load a new tone
		logic stop;        // halt the tone
		logic div_step;    // one quotient bit of the period division
		logic period_load; // take the division result as the period
	} tsw_cmd_t;

	typedef struct packed {
		logic freq_zero;   // incoming word asks for silence
	} tsw_sts_t;

endpackage

### rtl/tsw_ctrl.sv
// ----------------------------------------------------------------------------
// tsw_ctrl
// controller: handshakes, division sequencing and output word valid
// ----------------------------------------------------------------------------
module tsw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	output logic                out_valid,
	input  logic                out_ready,
	input  tsw_pkg::tsw_sts_t   sts,
	output tsw_pkg::tsw_cmd_t   cmd
);
	import tsw_pkg::*;

	tsw_state_t        state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              accept;
	logic              is_play;
	logic              need_div;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign is_play   = accept && (action == ACT_PLAY);
	assign need_div  = is_play && !sts.freq_zero;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd             = '0;
		cmd.tick        = accept && (action == ACT_TICK);
		cmd.play        = is_play;
		cmd.stop        = accept && (action == ACT_STOP);
		cmd.div_step    = (state_q == ST_DIV);
		cmd.period_load = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (need_div)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_BITS - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result is ready at once, except for a play that divides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && !need_div) || (state_q == ST_DONE)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input taken during division");
	a_no_result_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !out_valid_q)
		else $error("result shown before division finished");
	a_done_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_valid_q)
		else $error("division finished without a result word");
`endif

endmodule

### rtl/tsw_dp.sv
// ----------------------------------------------------------------------------
// tsw_dp
// datapath: tone counter, duration count, output level and period divider
// ----------------------------------------------------------------------------
module tsw_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [tsw_pkg::FREQ_W-1:0] freq_hz,
	input  logic [tsw_pkg::MS_W-1:0]   duration_ms,
	input  tsw_pkg::tsw_cmd_t          cmd,
	output tsw_pkg::tsw_sts_t          sts,
	output logic                       tone_out,
	output logic                       busy_res
);
	import tsw_pkg::*;

	logic [CNT_W-1:0]    counter_q;
	logic [CNT_W-1:0]    period_q;
	logic [CNT_W-1:0]    cmp_q;
	logic [REM_W-1:0]    remaining_q;
	logic                running_q;
	logic                busy_q;
	logic                level_q;

	// divider
	logic [FREQ_W-1:0]   dvs_q;
	logic [FREQ_W-1:0]   rem_q;
	logic [DIV_BITS-1:0] dvd_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [FREQ_W:0]     trial;
	logic                ge;
	logic [CNT_W-1:0]    period_sat;

	logic [PROD_W-1:0]   ticks;
	logic [REM_W-1:0]    ticks_sat;

	logic                wrap;
	logic [CNT_W-1:0]    counter_nx;
	logic                level_nx;

	assign sts.freq_zero = (freq_hz == '0);
	assign tone_out      = level_q;
	assign busy_res      = busy_q;

	// duration in ticks, saturated to the count width
	assign ticks     = PROD_W'(TICKS_PER_MS) * PROD_W'(duration_ms);
	assign ticks_sat = (ticks > PROD_W'(REM_MAX)) ? REM_MAX : ticks[REM_W-1:0];

	// restoring division, one quotient bit a step
	assign trial = {rem_q, dvd_q[DIV_BITS-1]};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign period_sat = (quo_q > DIV_BITS'(PERIOD_MAX)) ? PERIOD_MAX : quo_q[CNT_W-1:0];

	// tick step
	assign wrap       = (counter_q >= period_q);
	assign counter_nx = wrap ? '0 : counter_q + CNT_W'(1);
	always_comb begin
		level_nx = wrap ? 1'b1 : level_q;
		if (counter_nx == cmp_q)
			level_nx = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.play) begin
			dvs_q <= freq_hz;
			rem_q <= '0;
			dvd_q <= DIV_BITS'(CLOCK_HZ);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? FREQ_W'(trial - {1'b0, dvs_q}) : trial[FREQ_W-1:0];
			dvd_q <= {dvd_q[DIV_BITS-2:0], 1'b0};
			quo_q <= {quo_q[DIV_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q   <= '0;
			period_q    <= PERIOD_RESET;
			cmp_q       <= '0;
			remaining_q <= '0;
			running_q   <= 1'b0;
			busy_q      <= 1'b0;
			level_q     <= 1'b0;
		end else begin
			if (cmd.play) begin
				remaining_q <= ticks_sat;
				running_q   <= 1'b1;
				busy_q      <= 1'b1;
				if (sts.freq_zero) begin
					period_q <= CNT_W'(SILENT_PERIOD);
					cmp_q    <= '0;
				end
			end else if (cmd.stop) begin
				remaining_q <= '0;
				running_q   <= 1'b0;
				busy_q      <= 1'b0;
			end else if (cmd.period_load) begin
				period_q <= period_sat;
				cmp_q    <= period_sat >> 1;
			end else if (cmd.tick && running_q) begin
				counter_q <= counter_nx;
				level_q   <= level_nx;
				if (wrap) begin
					if (remaining_q == '0) begin
						running_q <= 1'b0;
						busy_q    <= 1'b0;
					end else if (remaining_q <= REM_W'(period_q)) begin
						remaining_q <= '0;
					end else begin
						remaining_q <= remaining_q - REM_W'(period_q);
					end
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_busy_tracks_run: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == running_q)
		else $error("busy and running disagree");
	a_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		period_q != '0)
		else $error("period is zero");
	a_level_held_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(running_q) |-> $stable(level_q))
		else $error("output level moved while stopped");
`endif

endmodule

### rtl/timed_square_wave_tone.sv
// ----------------------------------------------------------------------------
// timed_square_wave_tone
// tick-driven square-wave tone generator with a play duration
// ----------------------------------------------------------------------------
//
//   channel  signals                                 direction
//   input    in_valid in_ready action freq_hz         in
//            duration_ms
//   output   out_valid out_ready tone_out busy_res    out
//
// a tick, stop or silent play word has its result word registered at once;
// a play with a nonzero frequency first waits for the bit-serial division
// of the clock rate by the frequency
// (21 quotient bits, one per cycle, plus load and finish)
// arst_n clears counter, duration, busy and level and sets the period to 100
// a new word is taken while the previous result word leaves in the same cycle;
// an untaken result word holds off the input
// ----------------------------------------------------------------------------
module timed_square_wave_tone (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 action,
	input  logic [tsw_pkg::FREQ_W-1:0] freq_hz,
	input  logic [tsw_pkg::MS_W-1:0]   duration_ms,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       tone_out,
	output logic                       busy_res
);
	import tsw_pkg::*;

	// command and status between controller and datapath
	tsw_cmd_t cmd;
	tsw_sts_t sts;

	// controller: handshakes and division sequencing
	tsw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: tone state, divider; level and busy registers form the result word
	tsw_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.freq_hz     (freq_hz),
		.duration_ms (duration_ms),
		.cmd         (cmd),
		.sts         (sts),
		.tone_out    (tone_out),
		.busy_res    (busy_res)
	);

endmodule
